// ===== rtl/core/qbrd_pkg.sv =====
// ---------------------------------------------------------------------------
// qbrd_pkg
// Types, codes and divider constants shared by the QoS bit-rate and
// transfer-delay codec.
// ---------------------------------------------------------------------------
`default_nettype none

package qbrd_pkg;

   typedef enum logic [1:0] {
      CMD_DEC_RATE  = 2'd0,
      CMD_ENC_RATE  = 2'd1,
      CMD_DEC_DELAY = 2'd2,
      CMD_ENC_DELAY = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      DIV_100000 = 3'd0,
      DIV_10000  = 3'd1,
      DIV_4000   = 3'd2,
      DIV_2000   = 3'd3,
      DIV_1000   = 3'd4,
      DIV_100    = 3'd5,
      DIV_50     = 3'd6,
      DIV_10     = 3'd7
   } div_sel_type;

   localparam logic [1:0] EXT_NONE = 2'd0;
   localparam logic [1:0] EXT_ONE  = 2'd1;
   localparam logic [1:0] EXT_TWO  = 2'd2;

   localparam logic [7:0] EXT1_MARK = 8'hfe;
   localparam logic [7:0] EXT2_MARK = 8'hfa;

   // Reciprocal scale: quotient estimate is (n * recip) >> RECIP_SHIFT
   localparam int unsigned RECIP_SHIFT = 24;

   typedef struct packed {
      cmd_type     cmd;
      logic        is_div;
      logic [1:0]  lvl;
      logic [31:0] base;
      logic [23:0] op_a;
      logic [20:0] op_b;
      div_sel_type sel;
   } s1_type;

   typedef struct packed {
      cmd_type     cmd;
      logic        is_div;
      logic [1:0]  lvl;
      logic [31:0] base;
      logic [23:0] n;
      div_sel_type sel;
      logic [31:0] prod;
   } s2_type;

   typedef struct packed {
      cmd_type     cmd;
      logic        is_div;
      logic [1:0]  lvl;
      logic [31:0] value;
      logic [7:0]  q_est;
      logic [17:0] rem;
      div_sel_type sel;
   } s3_type;

   typedef struct packed {
      logic [31:0] rate_kbps;
      logic [7:0]  rate_octet;
      logic [7:0]  ext1_octet;
      logic [7:0]  ext2_octet;
      logic [1:0]  ext_level;
      logic [12:0] delay_ms;
      logic [5:0]  delay_octet;
   } rsp_type;

   function automatic logic [20:0] div_recip(input div_sel_type sel);
      logic [20:0] r;
      unique case (sel)
         DIV_100000: r = 21'd167;
         DIV_10000:  r = 21'd1677;
         DIV_4000:   r = 21'd4194;
         DIV_2000:   r = 21'd8388;
         DIV_1000:   r = 21'd16777;
         DIV_100:    r = 21'd167772;
         DIV_50:     r = 21'd335544;
         DIV_10:     r = 21'd1677721;
         default:    r = 21'd1677721;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] div_value(input div_sel_type sel);
      logic [16:0] d;
      unique case (sel)
         DIV_100000: d = 17'd100000;
         DIV_10000:  d = 17'd10000;
         DIV_4000:   d = 17'd4000;
         DIV_2000:   d = 17'd2000;
         DIV_1000:   d = 17'd1000;
         DIV_100:    d = 17'd100;
         DIV_50:     d = 17'd50;
         DIV_10:     d = 17'd10;
         default:    d = 17'd10;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qbrd_req_if.sv =====
// ---------------------------------------------------------------------------
// qbrd_req_if
// Request channel of the codec: valid/ready handshake and the input word.
// ---------------------------------------------------------------------------
`default_nettype none

interface qbrd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [7:0]  rate_octet_in;
   logic [7:0]  ext1_octet_in;
   logic [7:0]  ext2_octet_in;
   logic [31:0] rate_kbps_in;
   logic [7:0]  delay_octet_in;
   logic [15:0] delay_ms_in;

   modport source (
      output valid, cmd, rate_octet_in, ext1_octet_in, ext2_octet_in,
             rate_kbps_in, delay_octet_in, delay_ms_in,
      input  ready
   );
   modport sink (
      input  valid, cmd, rate_octet_in, ext1_octet_in, ext2_octet_in,
             rate_kbps_in, delay_octet_in, delay_ms_in,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/qbrd_rsp_if.sv =====
// ---------------------------------------------------------------------------
// qbrd_rsp_if
// Response channel of the codec: valid/ready handshake and the result word.
// ---------------------------------------------------------------------------
`default_nettype none

interface qbrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] rate_kbps_out;
   logic [7:0]  rate_octet_out;
   logic [7:0]  ext1_octet_out;
   logic [7:0]  ext2_octet_out;
   logic [1:0]  ext_level;
   logic [12:0] delay_ms_out;
   logic [5:0]  delay_octet_out;

   modport source (
      output valid, rate_kbps_out, rate_octet_out, ext1_octet_out, ext2_octet_out,
             ext_level, delay_ms_out, delay_octet_out,
      input  ready
   );
   modport sink (
      input  valid, rate_kbps_out, rate_octet_out, ext1_octet_out, ext2_octet_out,
             ext_level, delay_ms_out, delay_octet_out,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/qbrd_classify.sv =====
// ---------------------------------------------------------------------------
// qbrd_classify
// Stage 1: pick the band of each field and set up a base plus either a
// multiply by a step size or a divide by a step size.
// ---------------------------------------------------------------------------
`default_nettype none

module qbrd_classify import qbrd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   qbrd_req_if.sink    req,
   output logic        s1_valid_ff,
   input  logic        s1_ready,
   output s1_type      s1_ff
);

   logic        s1_valid_in;
   s1_type      s1_in;
   logic        load;
   logic [7:0]  b;
   logic [7:0]  e1;
   logic [7:0]  e2;
   logic [31:0] k;
   logic [31:0] k_576;
   logic [31:0] k_64;
   logic [5:0]  dc;
   logic [15:0] ms;
   logic [15:0] ms_c;

   assign b     = req.rate_octet_in;
   assign e1    = req.ext1_octet_in;
   assign e2    = req.ext2_octet_in;
   assign k     = req.rate_kbps_in;
   assign k_576 = k - 32'd576;
   assign k_64  = k - 32'd64;
   assign dc    = req.delay_octet_in[5:0];
   assign ms    = req.delay_ms_in;
   assign ms_c  = (ms > 16'd150) ? 16'd150 : ms;

   assign req.ready   = !s1_valid_ff || s1_ready;
   assign load        = req.valid && req.ready;
   assign s1_valid_in = req.ready ? req.valid : s1_valid_ff;

   always_comb begin
      s1_in      = '0;
      s1_in.cmd  = cmd_type'(req.cmd);
      s1_in.sel  = DIV_10;
      s1_in.lvl  = EXT_NONE;
      s1_in.op_b = 21'd1;
      unique case (s1_in.cmd)
         CMD_DEC_RATE: begin
            if (b == 8'h00) begin
               s1_in.base = '0;
            end else if (b == 8'hff) begin
               s1_in.base = '1;
            end else if (b == EXT1_MARK) begin
               if (e1 == 8'h00) begin
                  s1_in.base = 32'd8640;
               end else if (e1 == EXT2_MARK) begin
                  if (e2 >= 8'ha2 && e2 <= 8'hf6) begin
                     s1_in.base = 32'd1500000;
                     s1_in.op_a = 24'(e2 - 8'ha1);
                     s1_in.op_b = 21'd100000;
                  end else if (e2 >= 8'h3e && e2 <= 8'ha1) begin
                     s1_in.base = 32'd500000;
                     s1_in.op_a = 24'(e2 - 8'h3d);
                     s1_in.op_b = 21'd10000;
                  end else begin
                     s1_in.base = 32'd256000;
                     s1_in.op_a = 24'(e2);
                     s1_in.op_b = 21'd4000;
                  end
               end else if (e1 >= 8'hbb && e1 <= 8'hfa) begin
                  s1_in.base = 32'd128000;
                  s1_in.op_a = 24'(e1 - 8'hba);
                  s1_in.op_b = 21'd2000;
               end else if (e1 >= 8'h4b && e1 <= 8'hba) begin
                  s1_in.base = 32'd16000;
                  s1_in.op_a = 24'(e1 - 8'h4a);
                  s1_in.op_b = 21'd1000;
               end else begin
                  s1_in.base = 32'd8600;
                  s1_in.op_a = 24'(e1);
                  s1_in.op_b = 21'd100;
               end
            end else if (b[7]) begin
               s1_in.base = 32'd576;
               s1_in.op_a = 24'(b[6:0]);
               s1_in.op_b = 21'd64;
            end else if (b[6]) begin
               s1_in.base = 32'd64;
               s1_in.op_a = 24'(b[5:0]);
               s1_in.op_b = 21'd8;
            end else begin
               s1_in.base = 32'(b);
            end
         end
         CMD_ENC_RATE: begin
            s1_in.is_div = 1'b1;
            if (k >= 32'd260000) begin
               s1_in.lvl = EXT_TWO;
               if (k > 32'd10000000) begin
                  s1_in.base = 32'h0000_00f6;
               end else if (k >= 32'd1600000) begin
                  s1_in.base = 32'h0000_00a1;
                  s1_in.op_a = 24'(k - 32'd1500000);
                  s1_in.sel  = DIV_100000;
               end else if (k >= 32'd510000) begin
                  s1_in.base = 32'h0000_002d;
                  s1_in.op_a = 24'(k - 32'd500000);
                  s1_in.sel  = DIV_10000;
               end else begin
                  s1_in.op_a = 24'(k - 32'd256000);
                  s1_in.sel  = DIV_4000;
               end
            end else if (k >= 32'd8700) begin
               s1_in.lvl = EXT_ONE;
               if (k >= 32'd130000) begin
                  s1_in.base = 32'h0000_00ba;
                  s1_in.op_a = 24'(k - 32'd128000);
                  s1_in.sel  = DIV_2000;
               end else if (k >= 32'd17000) begin
                  s1_in.base = 32'h0000_004a;
                  s1_in.op_a = 24'(k - 32'd16000);
                  s1_in.sel  = DIV_1000;
               end else begin
                  s1_in.op_a = 24'(k - 32'd8600);
                  s1_in.sel  = DIV_100;
               end
            end else if (k >= 32'd576) begin
               s1_in.base = 32'(8'h80 + {1'b0, k_576[12:6]});
            end else if (k >= 32'd64) begin
               s1_in.base = 32'(8'h40 + {2'b0, k_64[8:3]});
            end else if (k != 32'd0) begin
               s1_in.base = 32'(k[5:0]);
            end else begin
               s1_in.base = 32'h0000_00ff;
            end
         end
         CMD_DEC_DELAY: begin
            if (dc <= 6'h0f) begin
               s1_in.op_a = 24'(dc);
               s1_in.op_b = 21'd10;
            end else if (dc <= 6'h1f) begin
               s1_in.base = 32'd200;
               s1_in.op_a = 24'(dc - 6'h10);
               s1_in.op_b = 21'd50;
            end else begin
               s1_in.base = 32'd1000;
               s1_in.op_a = 24'(dc - 6'h20);
               s1_in.op_b = 21'd100;
            end
         end
         CMD_ENC_DELAY: begin
            s1_in.is_div = 1'b1;
            if (ms >= 16'd4000) begin
               s1_in.base = 32'h0000_003e;
            end else if (ms >= 16'd1000) begin
               s1_in.base = 32'h0000_0020;
               s1_in.op_a = 24'(ms - 16'd1000);
               s1_in.sel  = DIV_100;
            end else if (ms >= 16'd200) begin
               s1_in.base = 32'h0000_0010;
               s1_in.op_a = 24'(ms - 16'd200);
               s1_in.sel  = DIV_50;
            end else if (ms_c >= 16'd10) begin
               s1_in.op_a = 24'(ms_c);
               s1_in.sel  = DIV_10;
            end else begin
               s1_in.base = 32'h0000_0001;
            end
         end
         default: begin
            s1_in.base = '0;
         end
      endcase
      if (s1_in.is_div) begin
         s1_in.op_b = div_recip(s1_in.sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= s1_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/qbrd_divmul.sv =====
// ---------------------------------------------------------------------------
// qbrd_divmul
// Stages 2 and 3: shared multiplier for step scaling and reciprocal
// division, then the remainder of the quotient estimate.
// ---------------------------------------------------------------------------
`default_nettype none

module qbrd_divmul import qbrd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        s1_valid,
   output logic        s1_ready,
   input  s1_type      s1,
   output logic        s3_valid_ff,
   input  logic        s3_ready,
   output s3_type      s3_ff
);

   logic        s2_valid_ff;
   logic        s2_valid_in;
   s2_type      s2_ff;
   s2_type      s2_in;
   logic        s2_ready;
   logic        s3_valid_in;
   s3_type      s3_in;
   logic [44:0] full_prod;
   logic [24:0] qd;
   logic [24:0] rem_wide;

   assign s2_ready    = !s3_valid_ff || s3_ready;
   assign s1_ready    = !s2_valid_ff || s2_ready;
   assign s2_valid_in = s1_ready ? s1_valid : s2_valid_ff;
   assign s3_valid_in = s2_ready ? s2_valid_ff : s3_valid_ff;

   assign full_prod = {21'b0, s1.op_a} * {24'b0, s1.op_b};

   always_comb begin
      s2_in        = '0;
      s2_in.cmd    = s1.cmd;
      s2_in.is_div = s1.is_div;
      s2_in.lvl    = s1.lvl;
      s2_in.base   = s1.base;
      s2_in.n      = s1.op_a;
      s2_in.sel    = s1.sel;
      s2_in.prod   = full_prod[31:0];
   end

   assign qd       = 25'(s2_ff.prod[RECIP_SHIFT +: 8]) * 25'(div_value(s2_ff.sel));
   assign rem_wide = {1'b0, s2_ff.n} - qd;

   always_comb begin
      s3_in        = '0;
      s3_in.cmd    = s2_ff.cmd;
      s3_in.is_div = s2_ff.is_div;
      s3_in.lvl    = s2_ff.lvl;
      s3_in.sel    = s2_ff.sel;
      s3_in.q_est  = s2_ff.prod[RECIP_SHIFT +: 8];
      s3_in.rem    = rem_wide[17:0];
      s3_in.value  = s2_ff.is_div ? s2_ff.base : s2_ff.base + s2_ff.prod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid && s1_ready) begin
         s2_ff <= s2_in;
      end
      if (s2_valid_ff && s2_ready) begin
         s3_ff <= s3_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/qbrd_format.sv =====
// ---------------------------------------------------------------------------
// qbrd_format
// Stage 4: correct the quotient, place the code in its octet or pass the
// decoded value through, and register the response word.
// ---------------------------------------------------------------------------
`default_nettype none

module qbrd_format import qbrd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        s3_valid,
   output logic        s3_ready,
   input  s3_type      s3,
   qbrd_rsp_if.source  rsp
);

   logic        out_valid_ff;
   logic        out_valid_in;
   rsp_type     out_ff;
   rsp_type     out_in;
   logic        fix;
   logic [7:0]  code;
   logic [31:0] value;

   assign s3_ready     = !out_valid_ff || rsp.ready;
   assign out_valid_in = s3_ready ? s3_valid : out_valid_ff;

   assign fix   = s3.rem >= {1'b0, div_value(s3.sel)};
   assign code  = s3.value[7:0] + s3.q_est + {7'b0, fix};
   assign value = s3.is_div ? {24'b0, code} : s3.value;

   always_comb begin
      out_in = '0;
      unique case (s3.cmd)
         CMD_DEC_RATE: begin
            out_in.rate_kbps = value;
         end
         CMD_ENC_RATE: begin
            out_in.ext_level = s3.lvl;
            unique case (s3.lvl)
               EXT_TWO: begin
                  out_in.rate_octet = EXT1_MARK;
                  out_in.ext1_octet = EXT2_MARK;
                  out_in.ext2_octet = code;
               end
               EXT_ONE: begin
                  out_in.rate_octet = EXT1_MARK;
                  out_in.ext1_octet = code;
               end
               default: begin
                  out_in.rate_octet = code;
               end
            endcase
         end
         CMD_DEC_DELAY: begin
            out_in.delay_ms = value[12:0];
         end
         CMD_ENC_DELAY: begin
            out_in.delay_octet = code[5:0];
         end
         default: begin
            out_in.rate_kbps = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid && s3_ready) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.rate_kbps_out   = out_ff.rate_kbps;
   assign rsp.rate_octet_out  = out_ff.rate_octet;
   assign rsp.ext1_octet_out  = out_ff.ext1_octet;
   assign rsp.ext2_octet_out  = out_ff.ext2_octet;
   assign rsp.ext_level       = out_ff.ext_level;
   assign rsp.delay_ms_out    = out_ff.delay_ms;
   assign rsp.delay_octet_out = out_ff.delay_octet;

endmodule

`default_nettype wire

// ===== rtl/core/qos_bit_rate_delay_codec.sv =====
// A request word passes the stage 1, 2, 3 and response registers.
// Throughput: one word per cycle unless the response side stalls; four
// pipeline registers, the response register included, and the shared 24x21
// multiplier in stage 2 set it. A response stall holds words; nothing drops.
// Reset clears the valid bits only; payload registers are not reset.
// ---------------------------------------------------------------------------
// qos_bit_rate_delay_codec
// GPRS QoS bit-rate and transfer-delay octet codec: decode and encode of the
// rate octets and the six-bit delay code, one word per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module qos_bit_rate_delay_codec import qbrd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   qbrd_req_if.sink    req,
   qbrd_rsp_if.source  rsp
);

   logic   s1_valid;
   logic   s1_ready;
   s1_type s1;
   logic   s3_valid;
   logic   s3_ready;
   s3_type s3;

   qbrd_classify u_classify (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .s1_valid_ff (s1_valid),
      .s1_ready    (s1_ready),
      .s1_ff       (s1)
   );

   qbrd_divmul u_divmul (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid),
      .s1_ready    (s1_ready),
      .s1          (s1),
      .s3_valid_ff (s3_valid),
      .s3_ready    (s3_ready),
      .s3_ff       (s3)
   );

   qbrd_format u_format (
      .clock    (clock),
      .reset    (reset),
      .s3_valid (s3_valid),
      .s3_ready (s3_ready),
      .s3       (s3),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire
